### hdl/wsp_pkg.sv
package wsp_pkg;

	localparam int SLOTS_DEF       = 16;
	localparam int WEIGHT_BITS_DEF = 24;
	localparam int FUNC_W          = 2;
	localparam int SLOT_W          = 4;
	localparam int ID_W            = 64;
	localparam int WEIGHT_W        = 24;
	localparam int KEY_W           = 64;

	localparam logic [FUNC_W-1:0] FUNC_WRITE   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_REBUILD = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_PICK    = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_SPARE   = 2'd3;

	localparam logic [0:0] MODE_RR       = 1'b0;
	localparam logic [0:0] MODE_WEIGHTED = 1'b1;

endpackage

### hdl/weighted_server_pick.sv
// weighted_server_pick: chooses a server from a slot table.
// s_axis carries one command beat (write slot, rebuild snapshot or pick);
// m_axis returns exactly one result beat per command, found = 0 for anything
// but a successful pick. cfg writes the pick mode (1 weighted, 0 round robin);
// the user must write it only while the block is idle; the block does not enforce this.
// Items are handled one at a time. A rebuild walks every slot through the
// table memories. A pick runs a 64-step restoring remainder of the key by the
// total weight or the snapshot count (one quotient bit per cycle), then a
// search of up to SLOTS prefix sums and a circular scan of up to SLOTS
// entries, each entry taking a memory read, then a compare.
// The result sits in an output register; s_axis_tready rises again the cycle
// after the result beat has been taken, so a stalled receiver holds the block.
// Reset clears the present/connected flags, the snapshot count, the pick mode
// (to weighted) and all control state; the id, weight and snapshot memories
// are not cleared and are only read after being written.
module weighted_server_pick
	import wsp_pkg::*;
#(
	parameter int SLOTS       = SLOTS_DEF,
	parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_data,        // pick_mode
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// func[1:0], slot[5:2], server_id[69:6], weight[93:70], present[94],
	// connected[95], key[159:96]
	input  logic [159:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// found[0], chosen_slot[4:1], chosen_id[68:5], zero fill [71:69]
	output logic [71:0]  m_axis_tdata
);

	localparam int AW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);
	localparam int PW = WEIGHT_BITS + AW;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_WRITE = 4'd1;
	localparam logic [3:0] ST_RB_RD = 4'd2;
	localparam logic [3:0] ST_RB_WR = 4'd3;
	localparam logic [3:0] ST_PK_RD = 4'd4;
	localparam logic [3:0] ST_PK_TT = 4'd5;
	localparam logic [3:0] ST_DIV   = 4'd6;
	localparam logic [3:0] ST_SR_RD = 4'd7;
	localparam logic [3:0] ST_SR_CK = 4'd8;
	localparam logic [3:0] ST_SC_RD = 4'd9;
	localparam logic [3:0] ST_SC_CK = 4'd10;
	localparam logic [3:0] ST_SC_ID = 4'd11;
	localparam logic [3:0] ST_ID_WT = 4'd12;
	localparam logic [3:0] ST_OUT   = 4'd13;

	logic [3:0]          state_q;
	logic                mode_q;
	logic [SLOTS-1:0]    present_q, connected_q;
	logic [CW-1:0]       count_q;
	logic [159:0]        in_q;
	logic [AW:0]         idx_q;     // rebuild slot index, one bit wider than a slot address
	logic [CW-1:0]       steps_q;
	logic [PW-1:0]       sum_q;
	logic [CW-1:0]       n_q;
	logic [KEY_W-1:0]    key_q;
	logic [PW:0]         rem_q;
	logic [PW-1:0]       div_q;
	logic [6:0]          bit_q;
	logic [AW-1:0]       pos_q;
	logic [AW-1:0]       chosen_q;
	logic                found_q;
	logic                out_valid_q;
	logic [ID_W-1:0]     id_out_q;

	logic [FUNC_W-1:0]   in_func;
	logic [SLOT_W-1:0]   in_slot;
	logic [ID_W-1:0]     in_id;
	logic [WEIGHT_W-1:0] in_weight;
	logic [KEY_W-1:0]    in_key;

	assign in_func   = in_q[1:0];
	assign in_slot   = in_q[5:2];
	assign in_id     = in_q[69:6];
	assign in_weight = in_q[93:70];
	assign in_key    = in_q[159:96];

	// memories
	logic                   id_we, w_we, ss_we, sp_we;
	logic [AW-1:0]          id_ra, w_ra, ss_ra, sp_ra, tbl_wa, snap_wa;
	logic [ID_W-1:0]        id_rd;
	logic [WEIGHT_BITS-1:0] w_rd;
	logic [AW-1:0]          ss_rd;
	logic [PW-1:0]          sp_rd;

	wsp_ram #(.WIDTH(ID_W), .DEPTH(SLOTS)) u_id_ram (
		.clk(clk), .we(id_we), .waddr(tbl_wa), .wdata(in_id), .raddr(id_ra), .rdata(id_rd));
	wsp_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(SLOTS)) u_w_ram (
		.clk(clk), .we(w_we), .waddr(tbl_wa),
		.wdata(WEIGHT_BITS'(in_weight)), .raddr(w_ra), .rdata(w_rd));
	wsp_ram #(.WIDTH(AW), .DEPTH(SLOTS)) u_ss_ram (
		.clk(clk), .we(ss_we), .waddr(snap_wa), .wdata(idx_q[AW-1:0]),
		.raddr(ss_ra), .rdata(ss_rd));
	wsp_ram #(.WIDTH(PW), .DEPTH(SLOTS)) u_sp_ram (
		.clk(clk), .we(sp_we), .waddr(snap_wa), .wdata(sum_q + PW'(w_rd)),
		.raddr(sp_ra), .rdata(sp_rd));

	logic slot_ok;
	assign slot_ok = (32'(in_slot) < SLOTS);
	assign tbl_wa  = AW'(in_slot);
	assign snap_wa = n_q[AW-1:0];

	logic rb_use;
	assign rb_use = present_q[idx_q[AW-1:0]] & connected_q[idx_q[AW-1:0]];

	assign id_we = (state_q == ST_WRITE) && slot_ok;
	assign w_we  = id_we;
	assign ss_we = (state_q == ST_RB_WR) && rb_use;
	assign sp_we = ss_we;

	assign w_ra  = idx_q[AW-1:0];
	assign id_ra = chosen_q;
	assign ss_ra = pos_q;
	assign sp_ra = (state_q == ST_PK_RD) ? AW'(count_q - CW'(1)) : pos_q;

	// remainder step
	logic [PW:0] rem_sh;
	logic        rem_ge;
	assign rem_sh = {rem_q[PW-1:0], key_q[KEY_W-1]};
	assign rem_ge = rem_sh >= {1'b0, div_q};

	logic scan_use;
	assign scan_use = present_q[ss_rd] & connected_q[ss_rd];

	logic s_acc, m_acc;
	assign s_acc = s_axis_tvalid && s_axis_tready;
	assign m_acc = m_axis_tvalid && m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE) && !out_valid_q;
	assign cfg_ready = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {3'b000, id_out_q, SLOT_W'(chosen_q), found_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= MODE_WEIGHTED;
			present_q   <= '0;
			connected_q <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			found_q     <= 1'b0;
			chosen_q    <= '0;
			id_out_q    <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				mode_q <= cfg_data;
			end
			if (m_acc) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						in_q     <= s_axis_tdata;
						found_q  <= 1'b0;
						chosen_q <= '0;
						idx_q    <= '0;
						sum_q    <= '0;
						n_q      <= '0;
						case (s_axis_tdata[1:0])
							FUNC_WRITE:   state_q <= ST_WRITE;
							FUNC_REBUILD: state_q <= ST_RB_RD;
							FUNC_PICK:    state_q <= (count_q == '0) ? ST_OUT : ST_PK_RD;
							default:      state_q <= ST_OUT;
						endcase
					end
				end
				ST_WRITE: begin
					if (slot_ok) begin
						present_q[AW'(in_slot)]   <= in_q[94];
						connected_q[AW'(in_slot)] <= in_q[95];
					end
					state_q <= ST_OUT;
				end
				ST_RB_RD: begin
					state_q <= ST_RB_WR;
				end
				ST_RB_WR: begin
					if (rb_use) begin
						sum_q <= sum_q + PW'(w_rd);
						n_q   <= n_q + CW'(1);
					end
					if (idx_q == (AW+1)'(SLOTS - 1)) begin
						count_q <= n_q + CW'(rb_use);
						state_q <= ST_OUT;
					end else begin
						idx_q   <= idx_q + (AW+1)'(1);
						state_q <= ST_RB_RD;
					end
				end
				ST_PK_RD: begin
					state_q <= ST_PK_TT;
				end
				ST_PK_TT: begin
					key_q <= in_key;
					rem_q <= '0;
					bit_q <= '0;
					if (mode_q == MODE_WEIGHTED) begin
						div_q   <= sp_rd;
						state_q <= (sp_rd == '0) ? ST_OUT : ST_DIV;
					end else begin
						div_q   <= PW'(count_q);
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q <= rem_ge ? (rem_sh - {1'b0, div_q}) : rem_sh;
					key_q <= {key_q[KEY_W-2:0], 1'b0};
					bit_q <= bit_q + 7'd1;
					if (bit_q == 7'(KEY_W - 1)) begin
						pos_q <= '0;
						if (mode_q == MODE_WEIGHTED) begin
							state_q <= ST_SR_RD;
						end else begin
							pos_q   <= rem_ge ? AW'(rem_sh - {1'b0, div_q}) : AW'(rem_sh);
							steps_q <= '0;
							state_q <= ST_SC_RD;
						end
					end
				end
				ST_SR_RD: begin
					state_q <= ST_SR_CK;
				end
				ST_SR_CK: begin
					// stop at first prefix above the remainder, else take the last entry
					steps_q <= '0;
					if ((sp_rd > rem_q[PW-1:0]) || (CW'(pos_q) == count_q - CW'(1))) begin
						state_q <= ST_SC_RD;
					end else begin
						pos_q   <= pos_q + AW'(1);
						state_q <= ST_SR_RD;
					end
				end
				ST_SC_RD: begin
					state_q <= ST_SC_CK;
				end
				ST_SC_CK: begin
					if (scan_use) begin
						found_q  <= 1'b1;
						chosen_q <= ss_rd;
						state_q  <= ST_SC_ID;
					end else if (steps_q == count_q - CW'(1)) begin
						state_q <= ST_OUT;
					end else begin
						steps_q <= steps_q + CW'(1);
						pos_q   <= (CW'(pos_q) == count_q - CW'(1)) ? '0 : pos_q + AW'(1);
						state_q <= ST_SC_RD;
					end
				end
				ST_SC_ID: begin
					state_q <= ST_ID_WT;
				end
				ST_ID_WT: begin
					id_out_q    <= id_rd;
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				ST_OUT: begin
					id_out_q    <= '0;
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_nf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[68:1] == '0))
		else $error("not-found result carries nonzero slot or id");
	a_cnt_rng: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= SLOTS)
		else $error("snapshot count beyond table");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !s_axis_tready)
		else $error("input ready while working");
	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[0]) |->
		(present_q[chosen_q] && connected_q[chosen_q]))
		else $error("chosen slot not usable");
`endif

endmodule

### hdl/wsp_ram.sv
module wsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### verif/tb_weighted_server_pick.sv
module tb_weighted_server_pick;
	import wsp_pkg::*;

	typedef struct packed {
		logic [1:0]  func;
		logic [3:0]  slot;
		logic [63:0] server_id;
		logic [23:0] weight;
		logic        present;
		logic        connected;
		logic [63:0] key;
	} cmd_t;

	typedef struct packed {
		logic        found;
		logic [3:0]  chosen_slot;
		logic [63:0] chosen_id;
	} pick_res_t;

	logic         clk;
	logic         arst_n;
	logic         cfg_valid;
	logic         cfg_ready;
	logic         cfg_data;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [159:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [71:0]  m_axis_tdata;

	weighted_server_pick u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// model state of the picker
	logic        mdl_mode;
	logic        mdl_present [16];
	logic        mdl_conn [16];
	logic [63:0] mdl_id [16];
	logic [23:0] mdl_weight [16];
	logic [3:0]  snap_slot [16];
	logic [27:0] snap_sum [16];
	int          snap_count;

	pick_res_t expected_picks[$];
	int        error_count;
	int        send_idle_pct;
	int        recv_stall_pct;
	int        hold_off_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#40000000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic logic usable(input int s);
		return mdl_present[s] && mdl_conn[s];
	endfunction

	function automatic pick_res_t predict_cmd(input cmd_t c);
		pick_res_t r;
		logic [63:0] total;
		logic [63:0] dis;
		int start;
		int pos;
		r = '0;
		if (c.func == FUNC_WRITE) begin
			mdl_id[c.slot] = c.server_id;
			mdl_weight[c.slot] = c.weight;
			mdl_present[c.slot] = c.present;
			mdl_conn[c.slot] = c.connected;
		end else if (c.func == FUNC_REBUILD) begin
			total = 0;
			snap_count = 0;
			for (int s = 0; s < 16; s++) begin
				if (usable(s)) begin
					total += mdl_weight[s];
					snap_slot[snap_count] = s[3:0];
					snap_sum[snap_count] = total[27:0];
					snap_count++;
				end
			end
		end else if (c.func == FUNC_PICK && snap_count > 0) begin
			start = -1;
			if (mdl_mode == MODE_WEIGHTED) begin
				total = 64'(snap_sum[snap_count-1]);
				if (total != 0) begin
					dis = c.key % total;
					start = snap_count - 1;
					for (int i = snap_count - 1; i >= 0; i--)
						if (64'(snap_sum[i]) > dis) start = i;
				end
			end else begin
				start = int'(c.key % 64'(snap_count));
			end
			if (start >= 0) begin
				for (int i = snap_count - 1; i >= 0; i--) begin
					pos = (start + i) % snap_count;
					if (usable(snap_slot[pos])) begin
						r.found = 1'b1;
						r.chosen_slot = snap_slot[pos];
					end
				end
				if (r.found) r.chosen_id = mdl_id[r.chosen_slot];
			end
		end
		return r;
	endfunction

	task automatic send_cmd(input cmd_t c);
		pick_res_t want;
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tdata <= {c.key, c.connected, c.present, c.weight, c.server_id,
			c.slot, c.func};
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		want = predict_cmd(c);
		expected_picks = {expected_picks, want};
		// valid drops at the next idle cycle or drain, or carries the next beat
		@(negedge clk);
	endtask

	task automatic send_write(input int s, input logic [63:0] id, input logic [23:0] w,
		input logic p, input logic cn);
		cmd_t c;
		c = '0;
		c.func = FUNC_WRITE;
		c.slot = s[3:0];
		c.server_id = id;
		c.weight = w;
		c.present = p;
		c.connected = cn;
		send_cmd(c);
	endtask

	task automatic send_op(input logic [1:0] f, input logic [63:0] k);
		cmd_t c;
		c = {$urandom, $urandom, $urandom, $urandom, $urandom};
		c.func = f;
		c.key = k;
		// keep slot fields random on rebuild and pick: they are ignored
		send_cmd(c);
	endtask

	task automatic drain;
		s_axis_tvalid <= 1'b0;
		while (expected_picks.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	task automatic write_mode(input logic m);
		drain();
		cfg_data <= m;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		mdl_mode = m;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_directed;
		send_op(FUNC_PICK, 64'd5);
		send_op(FUNC_REBUILD, 0);
		send_op(FUNC_PICK, '1);
		send_write(0, '1, 24'hFFFFFF, 1, 1);
		send_write(15, 64'h0123456789ABCDEF, 24'd1, 1, 1);
		send_write(7, 64'd0, 24'd0, 1, 1);
		send_write(3, 64'd33, 24'd10, 1, 0);
		send_write(4, 64'd44, 24'd10, 0, 1);
		send_op(FUNC_REBUILD, 0);
		send_op(FUNC_PICK, 64'd0);
		send_op(FUNC_PICK, '1);
		send_op(FUNC_PICK, 64'hFFFFFF);
		send_op(FUNC_SPARE, '1);
		// stale snapshot: slot 0 drops, slot 15 gets a new id
		send_write(0, 64'd1, 24'd5, 1, 0);
		send_write(15, 64'hDEAD, 24'd5, 1, 1);
		send_op(FUNC_PICK, 64'd3);
		send_write(15, 64'hDEAD, 24'd5, 0, 0);
		send_op(FUNC_PICK, 64'd3);
		send_write(7, 64'd9, 24'd0, 1, 1);
		send_op(FUNC_REBUILD, 0);
		send_op(FUNC_PICK, 64'd8);
		write_mode(MODE_RR);
		send_op(FUNC_PICK, 64'd8);
		send_op(FUNC_PICK, '1);
		write_mode(MODE_WEIGHTED);
	endtask

	task automatic test_random(input int n);
		int f;
		logic [23:0] w;
		for (int i = 0; i < n; i++) begin
			f = $urandom_range(99);
			if (f < 45) begin
				w = ($urandom_range(9) == 0) ? 24'($urandom) :
					($urandom_range(5) == 0 ? 24'd0 : 24'($urandom_range(40)));
				send_write($urandom_range(15), {$urandom, $urandom}, w,
					$urandom_range(3) != 0, $urandom_range(3) != 0);
			end else if (f < 55) begin
				send_op(FUNC_REBUILD, 0);
			end else if (f < 97) begin
				send_op(FUNC_PICK, $urandom_range(3) == 0 ? 64'($urandom_range(100)) :
					{$urandom, $urandom});
			end else begin
				send_op(FUNC_SPARE, {$urandom, $urandom});
			end
		end
	endtask

	task automatic test_backpressure;
		hold_off_cycles = 2000;
		test_random(30);
	endtask

	// result checker
	always @(posedge clk) begin
		pick_res_t got;
		pick_res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tdata[0], m_axis_tdata[4:1], m_axis_tdata[68:5]};
			if (expected_picks.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				error_count++;
			end else begin
				want = expected_picks.pop_front();
				if (got.found !== want.found) begin
					$display("%0t: found exp %h got %h", $time, want.found, got.found);
					error_count++;
				end
				if (got.chosen_slot !== want.chosen_slot) begin
					$display("%0t: chosen_slot exp %h got %h", $time,
						want.chosen_slot, got.chosen_slot);
					error_count++;
				end
				if (got.chosen_id !== want.chosen_id) begin
					$display("%0t: chosen_id exp %h got %h", $time,
						want.chosen_id, got.chosen_id);
					error_count++;
				end
			end
		end
	end

	// receiver ready, with a long hold-off when asked
	always @(negedge clk) begin
		if (hold_off_cycles > 0) begin
			m_axis_tready <= 1'b0;
			hold_off_cycles <= hold_off_cycles - 1;
		end else begin
			m_axis_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		error_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off_cycles = 0;
		mdl_mode = MODE_WEIGHTED;
		snap_count = 0;
		for (int s = 0; s < 16; s++) begin
			mdl_present[s] = 0;
			mdl_conn[s] = 0;
			mdl_id[s] = 0;
			mdl_weight[s] = 0;
		end
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random(450);
		send_idle_pct = 75;
		write_mode(MODE_RR);
		test_random(450);
		send_idle_pct = 0;
		recv_stall_pct = 75;
		write_mode(MODE_WEIGHTED);
		test_random(450);
		send_idle_pct = 29;
		recv_stall_pct = 29;
		write_mode(MODE_RR);
		test_random(300);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		write_mode(MODE_WEIGHTED);
		test_backpressure();
		test_random(250);
		drain();
		if (error_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
